FILE: rtl/core/tare_pkg.sv
// Shared types, codes and reset constants for the trigger/action rule engine.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package tare_pkg;

    localparam int DEF_MAX_RULES  = 8;
    localparam int DEF_VALUE_BITS = 8;
    localparam int MASK_W         = 8;
    localparam int PACK_W         = 64;

    // System modes.
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_LOCK   = 2'd1;
    localparam logic [1:0] MODE_SLEEP  = 2'd2;

    // Rule phases.
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_ARMED  = 2'd1;
    localparam logic [1:0] PH_ACTING = 2'd2;

    // Trigger relations.
    localparam logic [1:0] REL_EQUAL   = 2'd0;
    localparam logic [1:0] REL_GREATER = 2'd1;
    localparam logic [1:0] REL_LESS    = 2'd2;

    // Rule actions; both remaining codes mean sleep.
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_STOP  = 2'd1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_RULE_COUNT   = 3'd0;
    localparam logic [2:0] CFG_THRESHOLDS   = 3'd1;
    localparam logic [2:0] CFG_RELATIONS    = 3'd2;
    localparam logic [2:0] CFG_ACTIONS      = 3'd3;
    localparam logic [2:0] CFG_TIME_MASK    = 3'd4;
    localparam logic [2:0] CFG_RUN_DURATION = 3'd5;
    localparam logic [2:0] CFG_LOCK_SPAN    = 3'd6;
    localparam logic [2:0] CFG_WAKE_LEVEL   = 3'd7;

    localparam logic [7:0] RST_RUN_DURATION = 8'd20;
    localparam logic [7:0] RST_LOCK_SPAN    = 8'd2;
    localparam logic       RST_WAKE_LEVEL   = 1'b1;

    typedef struct packed {
        logic [1:0] phase_next;
        logic       start;
        logic       stop;
        logic       sleep;
    } lane_res_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       overtime;
        logic       switch_latched;
    } sys_state_t;

    typedef struct packed {
        logic [MASK_W-1:0] start_mask;
        logic [MASK_W-1:0] stop_mask;
        logic              make_mode;
        logic              shut_down;
        logic              detach_link;
        logic              restore;
        logic [1:0]        system_mode;
    } result_t;

endpackage

FILE: rtl/core/tare_lane.sv
// One rule lane: evaluates the trigger and the phase step of a single rule.
// Depends on tare_pkg; the result is registered when the lane stage is enabled.
module tare_lane #(
    parameter int VALUE_BITS = tare_pkg::DEF_VALUE_BITS
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic                  active,
    input  logic [1:0]            phase,
    input  logic [1:0]            action,
    input  logic [1:0]            relation,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [VALUE_BITS-1:0] threshold,
    input  logic                  running,
    input  logic                  time_trig,
    output tare_pkg::lane_res_t   lane_res
);

    tare_pkg::lane_res_t res_reg;
    tare_pkg::lane_res_t res_next;
    logic                hit;

    always_comb begin
        case (relation)
            tare_pkg::REL_EQUAL:   hit = (value == threshold);
            tare_pkg::REL_GREATER: hit = (value > threshold);
            tare_pkg::REL_LESS:    hit = (value < threshold);
            default:               hit = 1'b1;
        endcase
    end

    always_comb begin
        res_next            = '0;
        res_next.phase_next = phase;
        if (active) begin
            case (phase)
                tare_pkg::PH_ACTING: begin
                    // A stop rule on run time stays acting until a wake-up returns it to idle.
                    if (action == tare_pkg::ACT_START && !running) begin
                        res_next.phase_next = tare_pkg::PH_IDLE;
                    end else if (action == tare_pkg::ACT_STOP && !time_trig && running) begin
                        res_next.phase_next = tare_pkg::PH_IDLE;
                    end
                end
                tare_pkg::PH_IDLE: begin
                    if (hit) begin
                        res_next.phase_next = tare_pkg::PH_ARMED;
                    end
                end
                tare_pkg::PH_ARMED: begin
                    case (action)
                        tare_pkg::ACT_START: begin
                            res_next.start      = 1'b1;
                            res_next.phase_next = tare_pkg::PH_ACTING;
                        end
                        tare_pkg::ACT_STOP: begin
                            res_next.stop       = 1'b1;
                            res_next.phase_next = tare_pkg::PH_ACTING;
                        end
                        default: begin
                            res_next.sleep = 1'b1;
                        end
                    endcase
                end
                default: begin
                    res_next.phase_next = phase;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign lane_res = res_reg;

endmodule

FILE: rtl/core/tare_merge.sv
// Merging stage: truncates the scan at the first sleeping rule and steps the system mode.
// Depends on tare_pkg; purely combinational, committed by the top level.
module tare_merge #(
    parameter int MAX_RULES = tare_pkg::DEF_MAX_RULES
) (
    input  tare_pkg::lane_res_t lanes      [MAX_RULES],
    input  logic [1:0]          phase      [MAX_RULES],
    input  logic [MAX_RULES-1:0] active,
    input  tare_pkg::sys_state_t state,
    input  logic [7:0]          run_time,
    input  logic                switch_at_run,
    input  logic                pin_change,
    input  logic                wake_pin_level,
    input  logic [7:0]          run_duration,
    input  logic [7:0]          lock_span,
    input  logic                wake_level,
    output tare_pkg::sys_state_t state_next,
    output logic [1:0]          phase_next [MAX_RULES],
    output tare_pkg::result_t   result
);

    logic [MAX_RULES-1:0] sleep_vec;
    logic [MAX_RULES-1:0] below;
    logic                 overtime_now;
    logic                 lock_done;

    always_comb begin
        for (int i = 0; i < MAX_RULES; i++) begin
            sleep_vec[i] = lanes[i].sleep;
        end
        // Rules below the first sleeping rule take effect; the rest are left untouched.
        below        = (sleep_vec - MAX_RULES'(1)) & ~sleep_vec;
        overtime_now = state.overtime | (run_time >= run_duration);
        lock_done    = ({1'b0, run_time} >= ({1'b0, run_duration} + {1'b0, lock_span}));
    end

    always_comb begin
        state_next          = state;
        state_next.overtime = overtime_now;
        result              = '0;
        for (int i = 0; i < MAX_RULES; i++) begin
            phase_next[i] = phase[i];
        end
        case (state.mode)
            tare_pkg::MODE_NORMAL: begin
                for (int i = 0; i < MAX_RULES; i++) begin
                    if (below[i]) begin
                        phase_next[i]           = lanes[i].phase_next;
                        result.start_mask[i]    = lanes[i].start;
                        result.stop_mask[i]     = lanes[i].stop;
                    end
                end
                if (overtime_now || (|sleep_vec)) begin
                    state_next.overtime = 1'b1;
                    state_next.mode     = tare_pkg::MODE_LOCK;
                    result.shut_down    = 1'b1;
                end
            end
            tare_pkg::MODE_LOCK: begin
                if (lock_done) begin
                    if (switch_at_run && !state.switch_latched) begin
                        result.detach_link        = 1'b1;
                        state_next.switch_latched = 1'b1;
                    end
                    state_next.mode = tare_pkg::MODE_SLEEP;
                end
            end
            default: begin
                if (pin_change && (wake_pin_level == wake_level)) begin
                    result.restore            = 1'b1;
                    state_next.overtime       = 1'b0;
                    state_next.switch_latched = switch_at_run;
                    state_next.mode           = tare_pkg::MODE_NORMAL;
                    for (int i = 0; i < MAX_RULES; i++) begin
                        if (active[i]) begin
                            phase_next[i] = tare_pkg::PH_IDLE;
                        end
                    end
                end
            end
        endcase
        result.make_mode   = (|result.start_mask) ? state_next.switch_latched : 1'b0;
        result.system_mode = (state_next.mode > tare_pkg::MODE_SLEEP) ? tare_pkg::MODE_SLEEP
                                                                      : state_next.mode;
    end

endmodule

FILE: rtl/core/trigger_action_rule_engine.sv
// Top level of the trigger/action rule engine: registers, rule lanes and merging stage.
// Depends on tare_pkg, tare_lane and tare_merge.
//
//   channel   direction  handshake            contents
//   s_        in         s_valid / s_ready    one control tick
//   m_        out        m_valid / m_ready    masks, flags and mode after the tick
//   cfg_      in         cfg_we               register write, cfg_index selects
//
// A request passes capture, a lane stage in which all rule lanes evaluate side by side,
// and a merging stage that commits the state and loads the output register.
// A new request is taken in the cycle after the merge, even while a result still waits.
// The merge holds while the output register is full and not being taken.
// Reset clears the system state, all rule phases and the configuration registers to their reset values.
module trigger_action_rule_engine #(
    parameter int MAX_RULES  = tare_pkg::DEF_MAX_RULES,
    parameter int VALUE_BITS = tare_pkg::DEF_VALUE_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_trigger_values,
    input  logic [7:0]  s_actuators_running,
    input  logic [7:0]  s_run_time,
    input  logic        s_switch_at_run,
    input  logic        s_pin_change,
    input  logic        s_wake_pin_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_start_mask,
    output logic [7:0]  m_stop_mask,
    output logic        m_make_mode,
    output logic        m_shut_down,
    output logic        m_detach_link,
    output logic        m_restore,
    output logic [1:0]  m_system_mode,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LANE  = 2'd1;
    localparam logic [1:0] ST_MERGE = 2'd2;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;

    // Configuration registers.
    logic [3:0]  rule_count_reg;
    logic [63:0] thresholds_reg;
    logic [15:0] relations_reg;
    logic [15:0] actions_reg;
    logic [7:0]  time_mask_reg;
    logic [7:0]  run_duration_reg;
    logic [7:0]  lock_span_reg;
    logic        wake_level_reg;

    // Captured request.
    logic [63:0] values_reg;
    logic [7:0]  running_reg;
    logic [7:0]  run_time_reg;
    logic        switch_reg;
    logic        pin_change_reg;
    logic        pin_level_reg;

    tare_pkg::sys_state_t sys_reg;
    tare_pkg::sys_state_t sys_next;
    logic [1:0]           phase_reg      [MAX_RULES];
    logic [1:0]           phase_next     [MAX_RULES];
    tare_pkg::lane_res_t  lanes          [MAX_RULES];
    logic [MAX_RULES-1:0] active;
    logic [3:0]           count_sat;
    tare_pkg::result_t    result;
    tare_pkg::result_t    out_reg;
    logic                 out_valid_reg;
    logic                 accept;
    logic                 commit;

    assign s_ready = aresetn && (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign commit  = (state_reg == ST_MERGE) && (!out_valid_reg || m_ready);

    assign count_sat = (rule_count_reg > 4'(MAX_RULES)) ? 4'(MAX_RULES) : rule_count_reg;

    always_comb begin
        for (int i = 0; i < MAX_RULES; i++) begin
            active[i] = (4'(i) < count_sat);
        end
    end

    always_comb begin
        case (state_reg)
            ST_IDLE:  state_next = accept ? ST_LANE : ST_IDLE;
            ST_LANE:  state_next = ST_MERGE;
            ST_MERGE: state_next = commit ? ST_IDLE : ST_MERGE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            sys_reg          <= '{mode: tare_pkg::MODE_NORMAL, overtime: 1'b0,
                                  switch_latched: 1'b0};
            rule_count_reg   <= '0;
            thresholds_reg   <= '0;
            relations_reg    <= '0;
            actions_reg      <= '0;
            time_mask_reg    <= '0;
            run_duration_reg <= tare_pkg::RST_RUN_DURATION;
            lock_span_reg    <= tare_pkg::RST_LOCK_SPAN;
            wake_level_reg   <= tare_pkg::RST_WAKE_LEVEL;
            for (int i = 0; i < MAX_RULES; i++) begin
                phase_reg[i] <= tare_pkg::PH_IDLE;
            end
        end else begin
            state_reg <= state_next;
            if (commit) begin
                out_valid_reg <= 1'b1;
                sys_reg       <= sys_next;
                for (int i = 0; i < MAX_RULES; i++) begin
                    phase_reg[i] <= phase_next[i];
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    tare_pkg::CFG_RULE_COUNT:   rule_count_reg   <= cfg_wdata[3:0];
                    tare_pkg::CFG_THRESHOLDS:   thresholds_reg   <= cfg_wdata;
                    tare_pkg::CFG_RELATIONS:    relations_reg    <= cfg_wdata[15:0];
                    tare_pkg::CFG_ACTIONS:      actions_reg      <= cfg_wdata[15:0];
                    tare_pkg::CFG_TIME_MASK:    time_mask_reg    <= cfg_wdata[7:0];
                    tare_pkg::CFG_RUN_DURATION: run_duration_reg <= cfg_wdata[7:0];
                    tare_pkg::CFG_LOCK_SPAN:    lock_span_reg    <= cfg_wdata[7:0];
                    tare_pkg::CFG_WAKE_LEVEL:   wake_level_reg   <= cfg_wdata[0];
                    default:                    wake_level_reg   <= wake_level_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            values_reg     <= s_trigger_values;
            running_reg    <= s_actuators_running;
            run_time_reg   <= s_run_time;
            switch_reg     <= s_switch_at_run;
            pin_change_reg <= s_pin_change;
            pin_level_reg  <= s_wake_pin_level;
        end
        if (commit) begin
            out_reg <= result;
        end
    end

    for (genvar g = 0; g < MAX_RULES; g++) begin : g_lane
        tare_lane #(
            .VALUE_BITS (VALUE_BITS)
        ) u_lane (
            .aclk      (aclk),
            .en        (state_reg == ST_LANE),
            .active    (active[g]),
            .phase     (phase_reg[g]),
            .action    (actions_reg[2*g +: 2]),
            .relation  (relations_reg[2*g +: 2]),
            .value     (values_reg[8*g +: VALUE_BITS]),
            .threshold (thresholds_reg[8*g +: VALUE_BITS]),
            .running   (running_reg[g]),
            .time_trig (time_mask_reg[g]),
            .lane_res  (lanes[g])
        );
    end

    tare_merge #(
        .MAX_RULES (MAX_RULES)
    ) u_merge (
        .lanes          (lanes),
        .phase          (phase_reg),
        .active         (active),
        .state          (sys_reg),
        .run_time       (run_time_reg),
        .switch_at_run  (switch_reg),
        .pin_change     (pin_change_reg),
        .wake_pin_level (pin_level_reg),
        .run_duration   (run_duration_reg),
        .lock_span      (lock_span_reg),
        .wake_level     (wake_level_reg),
        .state_next     (sys_next),
        .phase_next     (phase_next),
        .result         (result)
    );

    assign m_valid       = out_valid_reg;
    assign m_start_mask  = out_reg.start_mask;
    assign m_stop_mask   = out_reg.stop_mask;
    assign m_make_mode   = out_reg.make_mode;
    assign m_shut_down   = out_reg.shut_down;
    assign m_detach_link = out_reg.detach_link;
    assign m_restore     = out_reg.restore;
    assign m_system_mode = out_reg.system_mode;

endmodule

FILE: rtl/core/tare_checker.sv
// Port-level checks for the rule engine, bound to the top level.
// Depends on tare_pkg and trigger_action_rule_engine.
module tare_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_start_mask,
    input logic [7:0] m_stop_mask,
    input logic       m_make_mode,
    input logic       m_shut_down,
    input logic       m_restore,
    input logic [1:0] m_system_mode
);

    // A stalled result must hold.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_start_mask) && $stable(m_stop_mask)
                                && $stable(m_system_mode))
        else $error("result changed while stalled");

    a_start_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_start_mask & m_stop_mask) == 8'd0)
        else $error("rule both started and stopped");

    a_make_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_make_mode |-> m_start_mask != 8'd0)
        else $error("make mode without a start");

    a_shut_lock: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_shut_down |-> m_system_mode == tare_pkg::MODE_LOCK)
        else $error("shut down without entering lock");

    a_restore_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_restore |-> m_system_mode == tare_pkg::MODE_NORMAL
                                 && m_start_mask == 8'd0 && !m_shut_down)
        else $error("restore did not return to normal mode");

endmodule

bind trigger_action_rule_engine tare_checker u_tare_checker (.*);

FILE: tb/tb_trigger_action_rule_engine.sv
// Self-checking testbench for trigger_action_rule_engine: control ticks are predicted in
// step with the block and every result is compared field by field.
// Depends on tare_pkg and the RTL under rtl/core only.
module tb_trigger_action_rule_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import tare_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_TICKS = 210;

    // Codes that the package leaves unnamed.
    localparam logic [1:0] REL_ANY       = 2'd3;
    localparam logic [1:0] ACT_SLEEP     = 2'd2;
    localparam logic [1:0] ACT_SLEEP_ALT = 2'd3;

    typedef struct packed {
        logic [63:0] trigger_values;
        logic [7:0]  actuators_running;
        logic [7:0]  run_time;
        logic        switch_at_run;
        logic        pin_change;
        logic        wake_pin_level;
    } tick_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_trigger_values = '0;
    logic [7:0]  s_actuators_running = '0;
    logic [7:0]  s_run_time = '0;
    logic        s_switch_at_run = 1'b0;
    logic        s_pin_change = 1'b0;
    logic        s_wake_pin_level = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_start_mask;
    logic [7:0]  m_stop_mask;
    logic        m_make_mode;
    logic        m_shut_down;
    logic        m_detach_link;
    logic        m_restore;
    logic [1:0]  m_system_mode;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = CFG_RULE_COUNT;
    logic [63:0] cfg_wdata = '0;

    trigger_action_rule_engine u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_trigger_values    (s_trigger_values),
        .s_actuators_running (s_actuators_running),
        .s_run_time          (s_run_time),
        .s_switch_at_run     (s_switch_at_run),
        .s_pin_change        (s_pin_change),
        .s_wake_pin_level    (s_wake_pin_level),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_start_mask        (m_start_mask),
        .m_stop_mask         (m_stop_mask),
        .m_make_mode         (m_make_mode),
        .m_shut_down         (m_shut_down),
        .m_detach_link       (m_detach_link),
        .m_restore           (m_restore),
        .m_system_mode       (m_system_mode),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata)
    );

    // Register copies, at their reset values.
    logic [3:0]  rule_total   = '0;
    logic [63:0] thresh_lanes = '0;
    logic [15:0] rel_bits     = '0;
    logic [15:0] act_bits     = '0;
    logic [7:0]  timed_rules  = '0;
    logic [7:0]  run_limit    = RST_RUN_DURATION;
    logic [7:0]  lock_extra   = RST_LOCK_SPAN;
    logic        wake_on      = RST_WAKE_LEVEL;

    // Predicted engine state.
    logic [1:0]  sys_mode = MODE_NORMAL;
    logic [1:0]  rule_stage [8] = '{default: PH_IDLE};
    logic        over_run    = 1'b0;
    logic        latched_run = 1'b0;

    tick_t   pending_ticks[$];
    result_t tick_outcomes_due[$];
    tick_t   on_wire;
    int      gap_left = 0;
    int      stall_left = 0;
    int      hold_left = 0;
    bit      hold_req = 1'b0;
    bit      hold_done = 1'b0;
    bit      quiet_tail = 1'b0;
    int      error_count = 0;
    int      cycle_count = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Advances the predicted engine by one control tick and returns its result.
    function automatic result_t advance_engine(input tick_t tk);
        result_t    r;
        logic [7:0] starts;
        logic [7:0] stops;
        logic [1:0] act;
        logic [1:0] rel;
        logic [7:0] v;
        logic [7:0] t;
        logic [8:0] sleep_at;
        logic       hit;
        logic       scan_over;
        int         n;
        r = '0;
        starts = '0;
        stops = '0;
        scan_over = 1'b0;
        n = (rule_total > 4'd8) ? 8 : int'(rule_total);
        sleep_at = {1'b0, run_limit} + {1'b0, lock_extra};
        if (tk.run_time >= run_limit)
            over_run = 1'b1;
        if (sys_mode == MODE_NORMAL) begin
            for (int i = 0; i < 8; i++) begin
                if (i < n && !scan_over) begin
                    act = act_bits[2*i +: 2];
                    rel = rel_bits[2*i +: 2];
                    case (rule_stage[i])
                        PH_ACTING: begin
                            if (act == ACT_START) begin
                                if (!tk.actuators_running[i])
                                    rule_stage[i] = PH_IDLE;
                            end else if (act == ACT_STOP) begin
                                if (!timed_rules[i] && tk.actuators_running[i])
                                    rule_stage[i] = PH_IDLE;
                            end
                        end
                        PH_IDLE: begin
                            v = tk.trigger_values[8*i +: 8];
                            t = thresh_lanes[8*i +: 8];
                            case (rel)
                                REL_EQUAL:   hit = (v == t);
                                REL_GREATER: hit = (v > t);
                                REL_LESS:    hit = (v < t);
                                default:     hit = 1'b1;
                            endcase
                            if (hit)
                                rule_stage[i] = PH_ARMED;
                        end
                        PH_ARMED: begin
                            if (act == ACT_START) begin
                                starts[i] = 1'b1;
                                rule_stage[i] = PH_ACTING;
                            end else if (act == ACT_STOP) begin
                                stops[i] = 1'b1;
                                rule_stage[i] = PH_ACTING;
                            end else begin
                                // A sleep rule ends the scan and stays armed.
                                over_run = 1'b1;
                                scan_over = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            if (over_run) begin
                r.shut_down = 1'b1;
                sys_mode = MODE_LOCK;
            end
        end else if (sys_mode == MODE_LOCK) begin
            if ({1'b0, tk.run_time} >= sleep_at) begin
                if (tk.switch_at_run && !latched_run) begin
                    r.detach_link = 1'b1;
                    latched_run = 1'b1;
                end
                sys_mode = MODE_SLEEP;
            end
        end else begin
            if (tk.pin_change && tk.wake_pin_level == wake_on) begin
                r.restore = 1'b1;
                over_run = 1'b0;
                for (int i = 0; i < 8; i++)
                    if (i < n)
                        rule_stage[i] = PH_IDLE;
                latched_run = tk.switch_at_run;
                sys_mode = MODE_NORMAL;
            end
        end
        r.start_mask = starts;
        r.stop_mask = stops;
        r.make_mode = (starts != '0) ? latched_run : 1'b0;
        r.system_mode = (sys_mode > MODE_SLEEP) ? MODE_SLEEP : sys_mode;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // Request driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                tick_outcomes_due.push_back(advance_engine(on_wire));
                if (!quiet_tail && $urandom_range(0, 9) == 0)
                    gap_left = $urandom_range(1, 17);
            end
            if (s_valid && !s_ready) begin
                // Hold the request until it is taken.
            end else if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_ticks.size() > 0) begin
                on_wire = pending_ticks.pop_front();
                s_valid <= 1'b1;
                s_trigger_values <= on_wire.trigger_values;
                s_actuators_running <= on_wire.actuators_running;
                s_run_time <= on_wire.run_time;
                s_switch_at_run <= on_wire.switch_at_run;
                s_pin_change <= on_wire.pin_change;
                s_wake_pin_level <= on_wire.wake_pin_level;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver back-pressure.
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (tick_outcomes_due.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    error_count++;
                end else begin
                    want = tick_outcomes_due.pop_front();
                    check_field("start_mask", want.start_mask, m_start_mask);
                    check_field("stop_mask", want.stop_mask, m_stop_mask);
                    check_field("make_mode", 8'(want.make_mode), 8'(m_make_mode));
                    check_field("shut_down", 8'(want.shut_down), 8'(m_shut_down));
                    check_field("detach_link", 8'(want.detach_link), 8'(m_detach_link));
                    check_field("restore", 8'(want.restore), 8'(m_restore));
                    check_field("system_mode", 8'(want.system_mode), 8'(m_system_mode));
                end
            end
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_trigger_action_rule_engine: done, errors");
        $finish;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_RULE_COUNT:   rule_total = data[3:0];
            CFG_THRESHOLDS:   thresh_lanes = data;
            CFG_RELATIONS:    rel_bits = data[15:0];
            CFG_ACTIONS:      act_bits = data[15:0];
            CFG_TIME_MASK:    timed_rules = data[7:0];
            CFG_RUN_DURATION: run_limit = data[7:0];
            CFG_LOCK_SPAN:    lock_extra = data[7:0];
            CFG_WAKE_LEVEL:   wake_on = data[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [3:0] rules, input logic [63:0] thr,
                              input logic [15:0] rel, input logic [15:0] act,
                              input logic [7:0] tmask, input logic [7:0] dur,
                              input logic [7:0] lock, input logic wake);
        write_reg(CFG_RULE_COUNT, 64'(rules));
        write_reg(CFG_THRESHOLDS, thr);
        write_reg(CFG_RELATIONS, 64'(rel));
        write_reg(CFG_ACTIONS, 64'(act));
        write_reg(CFG_TIME_MASK, 64'(tmask));
        write_reg(CFG_RUN_DURATION, 64'(dur));
        write_reg(CFG_LOCK_SPAN, 64'(lock));
        write_reg(CFG_WAKE_LEVEL, 64'(wake));
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Returns once nothing is queued, on the wire or awaited, plus a short margin.
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_ticks.size() != 0 || s_valid || tick_outcomes_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_actions();
        logic [15:0] a;
        int          r;
        for (int i = 0; i < 8; i++) begin
            r = $urandom_range(0, 9);
            if (r < 4)
                a[2*i +: 2] = ACT_START;
            else if (r < 8)
                a[2*i +: 2] = ACT_STOP;
            else if (r == 8)
                a[2*i +: 2] = ACT_SLEEP;
            else
                a[2*i +: 2] = ACT_SLEEP_ALT;
        end
        return a;
    endfunction

    function automatic logic [63:0] offset_lanes(input logic [63:0] base, input logic [7:0] d);
        logic [63:0] v;
        for (int i = 0; i < 8; i++)
            v[8*i +: 8] = base[8*i +: 8] + d;
        return v;
    endfunction

    // Readings that sit on, just above or just below the thresholds more often than not.
    function automatic logic [63:0] near_thresholds();
        logic [63:0] v;
        for (int i = 0; i < 8; i++) begin
            case ($urandom_range(0, 3))
                0:       v[8*i +: 8] = thresh_lanes[8*i +: 8];
                1:       v[8*i +: 8] = thresh_lanes[8*i +: 8] + 8'd1;
                2:       v[8*i +: 8] = thresh_lanes[8*i +: 8] - 8'd1;
                default: v[8*i +: 8] = 8'($urandom);
            endcase
        end
        return v;
    endfunction

    function automatic tick_t make_tick(input logic [63:0] vals, input logic [7:0] running,
                                        input logic [7:0] rt, input logic sw,
                                        input logic pin, input logic lvl);
        tick_t tk;
        tk.trigger_values = vals;
        tk.actuators_running = running;
        tk.run_time = rt;
        tk.switch_at_run = sw;
        tk.pin_change = pin;
        tk.wake_pin_level = lvl;
        return tk;
    endfunction

    // Run-time ramps through normal, lock and sleep, then a stretch of wake events,
    // with a sprinkling of fully random ticks.
    task automatic queue_ticks(input int count);
        logic [8:0] sleep_at;
        logic [7:0] rt;
        int         wake_left;
        int         step;
        sleep_at = {1'b0, run_limit} + {1'b0, lock_extra};
        rt = 8'($urandom_range(0, 3));
        wake_left = 0;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 11) == 0) begin
                pending_ticks.push_back(make_tick({$urandom, $urandom}, 8'($urandom),
                    8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom)));
            end else if (wake_left > 0) begin
                pending_ticks.push_back(make_tick(near_thresholds(), 8'($urandom),
                    8'($urandom), 1'($urandom), $urandom_range(0, 2) != 0, 1'($urandom)));
                wake_left--;
                if (wake_left == 0)
                    rt = 8'($urandom_range(0, run_limit / 2));
            end else begin
                pending_ticks.push_back(make_tick(near_thresholds(), 8'($urandom), rt,
                    1'($urandom), $urandom_range(0, 15) == 0, 1'($urandom)));
                step = $urandom_range(0, 3);
                rt = (int'(rt) + step > 255) ? 8'd255 : 8'(int'(rt) + step);
                if ({1'b0, rt} >= sleep_at + 9'd2 || rt == 8'd255)
                    wake_left = $urandom_range(3, 6);
            end
        end
    endtask

    initial begin
        logic [63:0] thr_dir;
        thr_dir = 64'h00_FF_7F_80_01_FE_FF_00;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: no rules, lock at 20, sleep at 22, wake on a high level.
        pending_ticks.push_back(make_tick('0, '0, 8'd0, 1'b0, 1'b0, 1'b0));
        pending_ticks.push_back(make_tick('1, '1, 8'd19, 1'b0, 1'b1, 1'b1));
        pending_ticks.push_back(make_tick('0, '0, 8'd20, 1'b0, 1'b0, 1'b0));
        pending_ticks.push_back(make_tick('0, '0, 8'd21, 1'b1, 1'b0, 1'b0));
        pending_ticks.push_back(make_tick('0, '0, 8'd22, 1'b1, 1'b0, 1'b0));
        pending_ticks.push_back(make_tick('1, '1, 8'd255, 1'b1, 1'b1, 1'b0));
        pending_ticks.push_back(make_tick('0, '0, 8'd0, 1'b0, 1'b1, 1'b1));
        wait_drained();

        // Every relation and action across eight rules; the last rule forces sleep.
        set_config(4'd8, thr_dir,
                   {REL_ANY, REL_LESS, REL_GREATER, REL_EQUAL,
                    REL_ANY, REL_LESS, REL_GREATER, REL_EQUAL},
                   {ACT_SLEEP_ALT, ACT_START, ACT_STOP, ACT_START,
                    ACT_STOP, ACT_START, ACT_STOP, ACT_START},
                   8'b0000_0010, 8'd100, 8'd3, 1'b0);
        pending_ticks.push_back(make_tick('0, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0));
        pending_ticks.push_back(make_tick('1, 8'hFF, 8'd1, 1'b0, 1'b0, 1'b0));
        pending_ticks.push_back(make_tick(thr_dir, 8'h00, 8'd2, 1'b1, 1'b0, 1'b0));
        pending_ticks.push_back(make_tick(offset_lanes(thr_dir, 8'd1), 8'h55, 8'd3,
                                          1'b0, 1'b0, 1'b0));
        pending_ticks.push_back(make_tick(offset_lanes(thr_dir, 8'hFF), 8'hAA, 8'd4,
                                          1'b0, 1'b0, 1'b0));
        pending_ticks.push_back(make_tick(thr_dir, 8'h00, 8'd5, 1'b0, 1'b0, 1'b0));
        pending_ticks.push_back(make_tick(thr_dir, 8'hFF, 8'd6, 1'b0, 1'b0, 1'b0));
        pending_ticks.push_back(make_tick(thr_dir, 8'h00, 8'd7, 1'b0, 1'b0, 1'b0));
        pending_ticks.push_back(make_tick(thr_dir, 8'h00, 8'd100, 1'b0, 1'b0, 1'b0));
        pending_ticks.push_back(make_tick(thr_dir, 8'h00, 8'd102, 1'b1, 1'b0, 1'b0));
        pending_ticks.push_back(make_tick(thr_dir, 8'h00, 8'd102, 1'b1, 1'b1, 1'b1));
        pending_ticks.push_back(make_tick(thr_dir, 8'h00, 8'd0, 1'b1, 1'b1, 1'b0));
        for (int k = 0; k < 4; k++)
            pending_ticks.push_back(make_tick(thr_dir, 8'h00, 8'(k), 1'b0, 1'b0, 1'b0));
        wait_drained();

        // Rule count above the maximum.
        set_config(4'd15, {$urandom, $urandom}, 16'($urandom), rand_actions(),
                   8'($urandom), 8'd30, 8'd5, 1'b1);
        queue_ticks(PHASE_TICKS);
        wait_drained();

        // No rules, zero durations; the receiver holds off for a long stretch here.
        set_config(4'd0, 64'h0, 16'h0000, 16'h0000, 8'h00, 8'd0, 8'd0, 1'b0);
        queue_ticks(PHASE_TICKS);
        hold_req = 1'b1;
        wait_drained();

        // Longest durations: the lock threshold needs the ninth bit.
        set_config(4'd8, '1, 16'hFFFF, rand_actions(), 8'hFF, 8'd255, 8'd255, 1'b0);
        queue_ticks(PHASE_TICKS);
        wait_drained();

        set_config(4'd3, {$urandom, $urandom}, 16'($urandom), rand_actions(),
                   8'($urandom), 8'd10, 8'd0, 1'b1);
        queue_ticks(PHASE_TICKS);
        wait_drained();

        set_config(4'd8, 64'h0, 16'($urandom), rand_actions(), 8'h00, 8'd60, 8'd20, 1'b1);
        queue_ticks(PHASE_TICKS);
        wait_drained();

        for (int p = 0; p < 2; p++) begin
            set_config(4'($urandom_range(0, 15)), {$urandom, $urandom}, 16'($urandom),
                       rand_actions(), 8'($urandom), 8'($urandom_range(5, 80)),
                       8'($urandom_range(0, 10)), 1'($urandom));
            queue_ticks(PHASE_TICKS);
            wait_drained();
        end

        // Final stretch runs at full rate on both sides.
        set_config(4'd8, {$urandom, $urandom}, 16'($urandom), rand_actions(),
                   8'($urandom), 8'd40, 8'd3, 1'b1);
        quiet_tail = 1'b1;
        queue_ticks(PHASE_TICKS);
        wait_drained();

        repeat (10) @(posedge aclk);
        if (error_count == 0)
            $display("tb_trigger_action_rule_engine: done, clean");
        else
            $display("tb_trigger_action_rule_engine: done, errors");
        $finish;
    end

endmodule
